### sv/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and constants of the first-fit partition allocator: word
// layouts, partition table entry and datapath command/status encodings.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned META_W      = 7;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam logic [ADDR_W-1:0] HEAP_RESET = 24'd65536;
  localparam logic [META_W-1:0] META_RESET = 7'd24;
  localparam logic [ADDR_W-1:0] ALIGN_BYTES = 24'd4;

  // Command codes
  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_COMPACT = 2'd2;
  localparam logic [1:0] CMD_INIT    = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_META_SIZE  = 1'd1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] req_size;
    logic [ADDR_W-1:0] free_addr;
  } ffpa_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] payload_offset;
  } ffpa_out_t;

  typedef struct packed {
    logic              used;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] size;
  } part_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_START,
    DP_INIT,
    DP_SCAN_RD,
    DP_SCAN_CHK,
    DP_MISS,
    DP_INS_RD,
    DP_INS_WR,
    DP_SPLIT_HOLE,
    DP_SPLIT_MARK,
    DP_MARK,
    DP_FREE_W,
    DP_MRG_START,
    DP_MRG_RD,
    DP_MRG_STEP,
    DP_MRG_END,
    DP_CMP_RD,
    DP_CMP_STEP,
    DP_CMP_END
  } dp_op_t;

  typedef struct packed {
    logic idx_lt_cnt;  // scan index still inside the table
    logic hit;         // entry just read matches the request
    logic split;       // hit entry is large enough to split and the table has room
    logic ins_more;    // entries left to shift up for an insert
  } dp_stat_t;

endpackage

### sv/first_fit_partition_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_partition_allocator_core
// First-fit heap partition allocator with coalescing and compaction.
// ----------------------------------------------------------------------------
// Each command word yields one result word. Commands walk the partition table
// one entry at a time, a read state then a check or step state per entry,
// through a table memory with one write port and one registered read port;
// alloc splits a hit entry by shifting later entries up, free adds a merge
// pass over the table, and compact makes one pass over it. After reset the
// block builds the initial table in its boot state before accepting words.
// Config writes are taken at any time; made while no command is in flight
// they apply from the next command. The table is rebuilt only by init or reset.
module first_fit_partition_allocator_core
  import ffpa_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 16
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ffpa_in_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ffpa_out_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data
);

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  ffpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_word.cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .op       (op)
  );

  ffpa_dp #(
    .MAX_PARTS(MAX_PARTS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_word  (in_word),
    .op       (op),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

### sv/ffpa_ctrl.sv
// ----------------------------------------------------------------------------
// ffpa_ctrl
// Command sequencer: accepts a word, steps the datapath through scan,
// insert, merge or compaction passes and presents the result word.
// ----------------------------------------------------------------------------
module ffpa_ctrl
  import ffpa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_stat_t   stat,
  output dp_op_t     op
);

  typedef enum logic [4:0] {
    S_BOOT, S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_INS_RD, S_INS_WR,
    S_SPLIT_HOLE, S_SPLIT_MARK, S_MARK, S_FREE_W, S_MRG_START, S_MRG_RD,
    S_MRG_STEP, S_MRG_END, S_CMP_RD, S_CMP_STEP, S_CMP_END, S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   is_alloc;

  assign in_ready = (state == S_IDLE) && !out_valid;

  // Next state and datapath command
  always_comb begin
    state_next = state;
    op         = DP_NOP;
    unique case (state)
      S_BOOT: begin
        op         = DP_INIT;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          op = DP_START;
          unique case (in_cmd)
            CMD_ALLOC, CMD_FREE: state_next = S_SCAN_RD;
            CMD_COMPACT:         state_next = S_CMP_RD;
            default:             state_next = S_INIT;
          endcase
        end
      end
      S_INIT: begin
        op         = DP_INIT;
        state_next = S_DONE;
      end
      S_SCAN_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = DP_SCAN_RD;
          state_next = S_SCAN_CHK;
        end else begin
          op         = DP_MISS;
          state_next = S_DONE;
        end
      end
      S_SCAN_CHK: begin
        op = DP_SCAN_CHK;
        if (!stat.hit) begin
          state_next = S_SCAN_RD;
        end else if (!is_alloc) begin
          state_next = S_FREE_W;
        end else if (stat.split) begin
          state_next = S_INS_RD;
        end else begin
          state_next = S_MARK;
        end
      end
      S_INS_RD: begin
        if (stat.ins_more) begin
          op         = DP_INS_RD;
          state_next = S_INS_WR;
        end else begin
          state_next = S_SPLIT_HOLE;
        end
      end
      S_INS_WR: begin
        op         = DP_INS_WR;
        state_next = S_INS_RD;
      end
      S_SPLIT_HOLE: begin
        op         = DP_SPLIT_HOLE;
        state_next = S_SPLIT_MARK;
      end
      S_SPLIT_MARK: begin
        op         = DP_SPLIT_MARK;
        state_next = S_DONE;
      end
      S_MARK: begin
        op         = DP_MARK;
        state_next = S_DONE;
      end
      S_FREE_W: begin
        op         = DP_FREE_W;
        state_next = S_MRG_START;
      end
      S_MRG_START: begin
        op         = DP_MRG_START;
        state_next = S_MRG_RD;
      end
      S_MRG_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = DP_MRG_RD;
          state_next = S_MRG_STEP;
        end else begin
          state_next = S_MRG_END;
        end
      end
      S_MRG_STEP: begin
        op         = DP_MRG_STEP;
        state_next = S_MRG_RD;
      end
      S_MRG_END: begin
        op         = DP_MRG_END;
        state_next = S_DONE;
      end
      S_CMP_RD: begin
        if (stat.idx_lt_cnt) begin
          op         = DP_CMP_RD;
          state_next = S_CMP_STEP;
        end else begin
          state_next = S_CMP_END;
        end
      end
      S_CMP_STEP: begin
        op         = DP_CMP_STEP;
        state_next = S_CMP_RD;
      end
      S_CMP_END: begin
        op         = DP_CMP_END;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_BOOT;
      out_valid <= 1'b0;
      is_alloc  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_valid && in_ready) begin
        is_alloc <= (in_cmd == CMD_ALLOC);
      end
    end
  end

endmodule

### sv/ffpa_dp.sv
// ----------------------------------------------------------------------------
// ffpa_dp
// Datapath: config registers, partition table memory, scan/shift pointers,
// merge and compaction accumulators and the result word.
// ----------------------------------------------------------------------------
module ffpa_dp
  import ffpa_pkg::*;
#(
  parameter int unsigned MAX_PARTS = 16
)(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  ffpa_in_t             in_word,
  input  dp_op_t               op,
  output dp_stat_t             stat,
  output ffpa_out_t            out_word
);

  localparam int unsigned IDX_W = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_PARTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // Config registers
  logic [ADDR_W-1:0] heap_total;
  logic [META_W-1:0] meta;

  // Partition table
  part_t mem [MAX_PARTS];
  part_t rdata;
  logic  we;
  logic [IDX_W-1:0] waddr;
  logic [IDX_W-1:0] raddr;
  part_t wdata;

  // Pointers and accumulators
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  k;
  logic [CNT_W-1:0]  n;
  logic [1:0]        cmd;
  logic [ADDR_W-1:0] r;        // rounded request, fits 24 bits once a hit exists
  logic              r_big;    // rounded request above 24 bits
  logic [ADDR_W-1:0] addr;
  part_t             ent;
  part_t             cur;
  logic              cur_valid;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] ft;
  logic              any_free;
  logic [1:0]        status;
  logic [ADDR_W-1:0] offset;

  logic [ADDR_W:0]   r_round;
  logic [ADDR_W+1:0] split_need;
  logic              alloc_hit;
  logic              free_hit;
  logic [ADDR_W-1:0] meta_ext;
  logic [ADDR_W-1:0] init_size;

  assign meta_ext  = {{(ADDR_W-META_W){1'b0}}, meta};
  assign init_size = (heap_total > meta_ext) ? (heap_total - meta_ext) : '0;
  assign r_round   = ({1'b0, in_word.req_size} + 25'd3) & ~25'd3;

  // Match logic on the word just read
  assign split_need = {2'b00, r} + {2'b00, meta_ext} + {2'b00, ALIGN_BYTES};
  assign alloc_hit  = !rdata.used && !r_big && (rdata.size >= r);
  assign free_hit   = rdata.used && ((rdata.off + meta_ext) == addr);

  assign stat.idx_lt_cnt = (idx < count);
  assign stat.hit        = (cmd == CMD_ALLOC) ? alloc_hit : free_hit;
  assign stat.split      = ({2'b00, rdata.size} >= split_need) && (count < CNT_MAX);
  assign stat.ins_more   = (k > (idx + CNT_ONE));

  assign out_word.status         = status;
  assign out_word.payload_offset = offset;

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    raddr = idx[IDX_W-1:0];
    wdata = ent;
    unique case (op)
      DP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{used: 1'b0, off: '0, size: init_size};
      end
      DP_INS_RD: begin
        raddr = IDX_W'(k - CNT_ONE);
      end
      DP_INS_WR: begin
        we    = 1'b1;
        waddr = k[IDX_W-1:0];
        wdata = rdata;
      end
      DP_SPLIT_HOLE: begin
        we    = 1'b1;
        waddr = IDX_W'(idx + CNT_ONE);
        wdata = '{used: 1'b0, off: ent.off + meta_ext + r,
                  size: ent.size - meta_ext - r};
      end
      DP_SPLIT_MARK: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, off: ent.off, size: r};
      end
      DP_MARK: begin
        we    = 1'b1;
        wdata = '{used: 1'b1, off: ent.off, size: ent.size};
      end
      DP_FREE_W: begin
        we    = 1'b1;
        wdata = '{used: 1'b0, off: ent.off, size: ent.size};
      end
      DP_MRG_STEP: begin
        we    = cur_valid && !(!cur.used && !rdata.used);
        waddr = n[IDX_W-1:0];
        wdata = cur;
      end
      DP_MRG_END: begin
        we    = 1'b1;
        waddr = n[IDX_W-1:0];
        wdata = cur;
      end
      DP_CMP_STEP: begin
        we    = rdata.used;
        waddr = n[IDX_W-1:0];
        wdata = '{used: 1'b1, off: pos, size: rdata.size};
      end
      DP_CMP_END: begin
        we    = any_free && (n < CNT_MAX);
        waddr = n[IDX_W-1:0];
        wdata = '{used: 1'b0, off: pos, size: ft - meta_ext};
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Table memory with registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_total <= HEAP_RESET;
      meta       <= META_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEAP_TOTAL: heap_total <= cfg_data;
        CFG_META_SIZE:  meta       <= cfg_data[META_W-1:0];
        default:        heap_total <= heap_total;
      endcase
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= CNT_ONE;
      idx       <= '0;
      k         <= '0;
      n         <= '0;
      cur_valid <= 1'b0;
    end else begin
      unique case (op)
        DP_START: begin
          idx       <= '0;
          n         <= '0;
          cur_valid <= 1'b0;
        end
        DP_INIT: count <= CNT_ONE;
        DP_SCAN_CHK: begin
          if (stat.hit) begin
            k <= count;
          end else begin
            idx <= idx + CNT_ONE;
          end
        end
        DP_INS_WR: k <= k - CNT_ONE;
        DP_SPLIT_MARK: count <= count + CNT_ONE;
        DP_MRG_START: begin
          idx       <= '0;
          n         <= '0;
          cur_valid <= 1'b0;
        end
        DP_MRG_RD: idx <= idx + CNT_ONE;
        DP_MRG_STEP: begin
          cur_valid <= 1'b1;
          if (cur_valid && !(!cur.used && !rdata.used)) begin
            n <= n + CNT_ONE;
          end
        end
        DP_MRG_END: count <= n + CNT_ONE;
        DP_CMP_RD: idx <= idx + CNT_ONE;
        DP_CMP_STEP: begin
          if (rdata.used) begin
            n <= n + CNT_ONE;
          end
        end
        DP_CMP_END: begin
          count <= (any_free && (n < CNT_MAX)) ? (n + CNT_ONE) : n;
        end
        default: count <= count;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      DP_START: begin
        cmd      <= in_word.cmd;
        r        <= r_round[ADDR_W-1:0];
        r_big    <= r_round[ADDR_W];
        addr     <= in_word.free_addr;
        pos      <= '0;
        ft       <= '0;
        any_free <= 1'b0;
        status   <= ST_OK;
        offset   <= '0;
      end
      DP_SCAN_CHK: begin
        if (stat.hit) begin
          ent <= rdata;
        end
      end
      DP_MISS: begin
        status <= (cmd == CMD_ALLOC) ? ST_NO_FIT : ST_BAD_ADDR;
      end
      DP_SPLIT_MARK, DP_MARK: begin
        offset <= ent.off + meta_ext;
      end
      DP_MRG_STEP: begin
        if (!cur_valid || !(!cur.used && !rdata.used)) begin
          cur <= rdata;
        end else begin
          cur.size <= cur.size + meta_ext + rdata.size;
        end
      end
      DP_CMP_STEP: begin
        if (rdata.used) begin
          pos <= pos + meta_ext + rdata.size;
        end else begin
          ft       <= ft + rdata.size + meta_ext;
          any_free <= 1'b1;
        end
      end
      default: begin
        offset <= offset;
      end
    endcase
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit partition allocator. A directed
// stimulus table covers reset state, extremes and error codes, then random
// command sequences run against a model of the partition table. Both sides
// idle at random, and one long output stall makes the block back up.
// ----------------------------------------------------------------------------
module tb_top;
  import ffpa_pkg::*;

  localparam int NPARTS = 16;
  localparam int WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  ffpa_in_t in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ffpa_out_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0] cfg_data = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  first_fit_partition_allocator_core #(.MAX_PARTS(NPARTS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Model of the partition table
  logic [23:0] heap_total;
  logic [6:0]  hdr_bytes;
  logic [23:0] tbl_off [NPARTS];
  logic [23:0] tbl_size [NPARTS];
  logic        tbl_used [NPARTS];
  int          tbl_cnt;

  ffpa_out_t result_q[$];
  int errors = 0;
  int accepted = 0;
  bit stimulus_done = 0;
  bit hold_off = 0;

  function automatic void table_init();
    for (int k = 0; k < NPARTS; k++) begin
      tbl_off[k] = '0; tbl_size[k] = '0; tbl_used[k] = 1'b0;
    end
    tbl_size[0] = (heap_total > hdr_bytes) ? heap_total - hdr_bytes : 24'd0;
    tbl_cnt = 1;
  endfunction

  function automatic void table_remove(int at);
    for (int k = at; k + 1 < tbl_cnt; k++) begin
      tbl_off[k] = tbl_off[k+1]; tbl_size[k] = tbl_size[k+1]; tbl_used[k] = tbl_used[k+1];
    end
    tbl_cnt--;
  endfunction

  // Work out the result of one command and update the table
  function automatic ffpa_out_t allocator_step(ffpa_in_t w);
    ffpa_out_t r;
    int i;
    int n;
    logic [31:0] rnd;
    logic [23:0] pos;
    logic [23:0] free_sum;
    bit any_free;
    r = '0;
    case (w.cmd)
      CMD_ALLOC: begin
        rnd = ((32'(w.req_size) + 32'd3) / 32'd4) * 32'd4;
        for (i = 0; i < tbl_cnt; i++)
          if (!tbl_used[i] && 32'(tbl_size[i]) >= rnd) break;
        if (i >= tbl_cnt) begin
          r.status = ST_NO_FIT;
        end else begin
          if (32'(tbl_size[i]) >= rnd + hdr_bytes + 32'd4 && tbl_cnt < NPARTS) begin
            for (int k = tbl_cnt; k > i + 1; k--) begin
              tbl_off[k] = tbl_off[k-1]; tbl_size[k] = tbl_size[k-1];
              tbl_used[k] = tbl_used[k-1];
            end
            tbl_off[i+1] = tbl_off[i] + 24'(hdr_bytes) + rnd[23:0];
            tbl_size[i+1] = tbl_size[i] - 24'(hdr_bytes) - rnd[23:0];
            tbl_used[i+1] = 1'b0;
            tbl_cnt++;
            tbl_size[i] = rnd[23:0];
          end
          tbl_used[i] = 1'b1;
          r.status = ST_OK;
          r.payload_offset = tbl_off[i] + 24'(hdr_bytes);
        end
      end
      CMD_FREE: begin
        for (i = 0; i < tbl_cnt; i++)
          if (tbl_used[i] && tbl_off[i] + 24'(hdr_bytes) == w.free_addr) break;
        if (i >= tbl_cnt) begin
          r.status = ST_BAD_ADDR;
        end else begin
          tbl_used[i] = 1'b0;
          i = 0;
          while (i + 1 < tbl_cnt) begin
            if (!tbl_used[i] && !tbl_used[i+1]) begin
              tbl_size[i] = tbl_size[i] + 24'(hdr_bytes) + tbl_size[i+1];
              table_remove(i + 1);
            end else begin
              i++;
            end
          end
        end
      end
      CMD_COMPACT: begin
        n = 0; pos = '0; free_sum = '0; any_free = 0;
        for (i = 0; i < tbl_cnt; i++) begin
          if (tbl_used[i]) begin
            tbl_off[n] = pos; tbl_size[n] = tbl_size[i]; tbl_used[n] = 1'b1;
            pos = pos + 24'(hdr_bytes) + tbl_size[i];
            n++;
          end else begin
            free_sum = free_sum + tbl_size[i] + 24'(hdr_bytes);
            any_free = 1;
          end
        end
        if (any_free && n < NPARTS) begin
          tbl_off[n] = pos; tbl_size[n] = free_sum - 24'(hdr_bytes);
          tbl_used[n] = 1'b0;
          n++;
        end
        tbl_cnt = n;
      end
      default: table_init();
    endcase
    return r;
  endfunction

  // Payload address of a random occupied partition, or a random address
  function automatic logic [23:0] pick_free_addr();
    int used_idx[$];
    for (int k = 0; k < tbl_cnt; k++) if (tbl_used[k]) used_idx.push_back(k);
    if (used_idx.size() > 0 && $urandom_range(0, 9) < 8)
      return tbl_off[used_idx[$urandom_range(0, used_idx.size() - 1)]] + 24'(hdr_bytes);
    return 24'($urandom);
  endfunction

  // Send one command word; a known expectation is checked against the model where given
  task automatic send_cmd(ffpa_in_t w, bit has_known, ffpa_out_t known);
    ffpa_out_t pred;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = allocator_step(w);
    if (has_known) begin
      if (pred.status !== known.status) begin
        $error("table row status: expected %0d, model %0d", known.status, pred.status);
        errors++;
      end
      if (pred.payload_offset !== known.payload_offset) begin
        $error("table row payload_offset: expected %h, model %h",
               known.payload_offset, pred.payload_offset);
        errors++;
      end
    end
    result_q.push_back(pred);
    accepted++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HEAP_TOTAL) heap_total = val;
    else hdr_bytes = val[6:0];
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (result_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic ffpa_in_t mk(logic [1:0] c, logic [23:0] sz, logic [23:0] ad);
    ffpa_in_t w;
    w.cmd = c; w.req_size = sz; w.free_addr = ad;
    return w;
  endfunction

  function automatic ffpa_out_t rs(logic [1:0] st, logic [23:0] off);
    ffpa_out_t o;
    o.status = st; o.payload_offset = off;
    return o;
  endfunction

  // Directed stimulus table
  typedef struct {
    ffpa_in_t  w;
    bit        known;
    ffpa_out_t exp_res;
  } row_t;

  // Output side: random stalls, one long hold-off, compare against the queue
  always @(posedge clk) begin
    ffpa_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_word);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_word.status);
            errors++;
          end
          if (out_word.payload_offset !== want.payload_offset) begin
            $error("payload_offset: expected %h, got %h",
                   want.payload_offset, out_word.payload_offset);
            errors++;
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(0, 14) < 10);
    end
  end

  // Long receiver stall, counted in cycles
  initial begin
    @(negedge rst);
    repeat (3000) @(posedge clk);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
  end

  // Watchdog on cycles without any accepted word
  initial begin
    int idle_cyc;
    idle_cyc = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cyc = 0;
      else if (!hold_off && !(stimulus_done && result_q.size() == 0))
        idle_cyc++;
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  initial begin
    row_t rows[$];
    int kind;
    int phase;
    heap_total = HEAP_RESET;
    hdr_bytes = META_RESET;
    table_init();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // After reset: heap 65536, header 24
    rows.push_back('{mk(CMD_ALLOC, 24'd0, 24'd0), 1, rs(ST_OK, 24'd24)});
    rows.push_back('{mk(CMD_ALLOC, 24'd5, 24'd0), 1, rs(ST_OK, 24'd48)});
    rows.push_back('{mk(CMD_ALLOC, 24'hFFFFFF, 24'd0), 1, rs(ST_NO_FIT, 24'd0)});
    rows.push_back('{mk(CMD_FREE, 24'd0, 24'hFFFFFF), 1, rs(ST_BAD_ADDR, 24'd0)});
    rows.push_back('{mk(CMD_FREE, 24'd0, 24'd24), 1, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_FREE, 24'd0, 24'd24), 1, rs(ST_BAD_ADDR, 24'd0)});
    rows.push_back('{mk(CMD_COMPACT, 24'd0, 24'd0), 1, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_ALLOC, 24'd100, 24'd0), 0, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_ALLOC, 24'd65000, 24'd0), 0, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_COMPACT, 24'd0, 24'd0), 0, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_INIT, 24'hFFFFFF, 24'hFFFFFF), 1, rs(ST_OK, 24'd0)});
    for (int k = 0; k < 17; k++)
      rows.push_back('{mk(CMD_ALLOC, 24'd4, 24'd0), 0, rs(ST_OK, 24'd0)});
    rows.push_back('{mk(CMD_COMPACT, 24'd0, 24'd0), 0, rs(ST_OK, 24'd0)});
    foreach (rows[k]) send_cmd(rows[k].w, rows[k].known, rows[k].exp_res);
    wait_idle();

    // Random phases over several register settings
    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin write_reg(CFG_HEAP_TOTAL, 24'd64); write_reg(CFG_META_SIZE, 24'd4); end
        1: begin write_reg(CFG_HEAP_TOTAL, 24'hFFFFFF); write_reg(CFG_META_SIZE, 24'd64); end
        2: begin write_reg(CFG_HEAP_TOTAL, 24'd40); write_reg(CFG_META_SIZE, 24'd64); end
        3: write_reg(CFG_META_SIZE, 24'h7F);
        default: begin
          write_reg(CFG_HEAP_TOTAL, 24'($urandom_range(64, 4096)));
          write_reg(CFG_META_SIZE, 24'($urandom_range(4, 64)));
        end
      endcase
      // A phase may start without init, so a stale table meets new registers
      if (phase != 3) send_cmd(mk(CMD_INIT, 24'($urandom), 24'($urandom)), 0, '0);
      for (int k = 0; k < 62; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 50)
          send_cmd(mk(CMD_ALLOC, ($urandom_range(0, 19) == 0) ? 24'($urandom)
                      : 24'($urandom_range(0, heap_total / 6 + 8)), 24'($urandom)), 0, '0);
        else if (kind < 88)
          send_cmd(mk(CMD_FREE, 24'($urandom), pick_free_addr()), 0, '0);
        else if (kind < 96)
          send_cmd(mk(CMD_COMPACT, 24'($urandom), 24'($urandom)), 0, '0);
        else
          send_cmd(mk(CMD_INIT, 24'($urandom), 24'($urandom)), 0, '0);
      end
      wait_idle();
    end

    stimulus_done = 1;
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule

### filelist.f
sv/ffpa_pkg.sv
sv/ffpa_ctrl.sv
sv/ffpa_dp.sv
sv/first_fit_partition_allocator_core.sv
tb/tb_top.sv
